### src/uaf_pkg.sv
// ----------------------------------------------------------------------------
// uaf_pkg
// Shared types, codes and helper functions for the unsigned ASCII formatter.
// ----------------------------------------------------------------------------
package uaf_pkg;

  // Mode codes on the func input
  localparam logic [1:0] FUNC_HEX_LOWER = 2'd0;
  localparam logic [1:0] FUNC_HEX_UPPER = 2'd1;
  localparam logic [1:0] FUNC_DEC       = 2'd2;

  // Geometry
  localparam int NIBBLES     = 16;
  localparam int DEC_DIGITS  = 10;
  localparam int DEC_BITS    = 32;
  localparam int BITS_PER_STEP = 2;
  localparam int DEC_STEPS   = DEC_BITS / BITS_PER_STEP;
  localparam int BCD_W       = DEC_DIGITS * 4;

  // ASCII bases
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;

  // Front-end sequencer states
  typedef enum logic [1:0] {
    FE_IDLE,
    FE_CONV,
    FE_DONE
  } fe_state_t;

  // One formatted request waiting between front and back
  typedef struct packed {
    logic [NIBBLES*4-1:0] digits;  // one digit per nibble, least significant low
    logic [4:0]           count;   // characters in the run
    logic                 upper;   // upper-case hex letters
  } entry_t;

  // Number of significant nibbles, at least one
  function automatic logic [4:0] digit_count_of(input logic [NIBBLES*4-1:0] d);
    logic [4:0] n;
    n = 5'd1;
    for (int i = 1; i < NIBBLES; i++) begin
      if (d[i*4 +: 4] != 4'd0) n = 5'(i + 1);
    end
    return n;
  endfunction

  // One double-dabble step: adjust every BCD digit, then shift in one bit
  function automatic logic [BCD_W-1:0] dabble(input logic [BCD_W-1:0] bcd,
                                              input logic             b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
    end
    return {adj[BCD_W-2:0], b};
  endfunction

  // Nibble to ASCII character
  function automatic logic [7:0] to_ascii(input logic [3:0] nib, input logic upper);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = ASCII_ZERO + {4'd0, nib};
    end else begin
      c = (upper ? ASCII_UPPER_A : ASCII_LOWER_A) + {4'd0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

### src/uaf_front.sv
// ----------------------------------------------------------------------------
// uaf_front
// Accepts requests, drops unused modes, converts decimal to BCD two bits
// per cycle and writes one digit record into the queue.
// ----------------------------------------------------------------------------
module uaf_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  logic [63:0]     value,
  input  logic [1:0]      func,
  input  logic            q_full,
  output logic            wr_en,
  output uaf_pkg::entry_t wr_entry
);
  import uaf_pkg::*;

  fe_state_t             state, state_next;
  logic [NIBBLES*4-1:0]  digits, digits_next;
  logic                  upper, upper_next;
  logic [DEC_BITS-1:0]   bin, bin_next;
  logic [$clog2(DEC_STEPS)-1:0] step, step_next;
  logic [BCD_W-1:0]      bcd_a, bcd_b;

  // Two dabble steps per cycle, MSBs of the binary first
  always_comb begin
    bcd_a = dabble(digits[BCD_W-1:0], bin[DEC_BITS-1]);
    bcd_b = dabble(bcd_a, bin[DEC_BITS-2]);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    digits <= digits_next;
    upper  <= upper_next;
    bin    <= bin_next;
    step   <= step_next;
  end

  // Next state and outputs
  always_comb begin
    state_next  = state;
    digits_next = digits;
    upper_next  = upper;
    bin_next    = bin;
    step_next   = step;
    wr_en       = 1'b0;
    full        = (state != FE_IDLE);
    wr_entry.digits = digits;
    wr_entry.count  = digit_count_of(digits);
    wr_entry.upper  = upper;
    case (state)
      FE_IDLE: begin
        if (push) begin
          if (func == FUNC_HEX_LOWER || func == FUNC_HEX_UPPER) begin
            digits_next = value;
            upper_next  = (func == FUNC_HEX_UPPER);
            state_next  = FE_DONE;
          end else if (func == FUNC_DEC) begin
            digits_next = '0;
            upper_next  = 1'b0;
            bin_next    = value[DEC_BITS-1:0];
            step_next   = '0;
            state_next  = FE_CONV;
          end
        end
      end
      FE_CONV: begin
        digits_next = {{(NIBBLES*4-BCD_W){1'b0}}, bcd_b};
        bin_next    = {bin[DEC_BITS-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
        step_next   = step + 1'b1;
        if (step == $bits(step)'(DEC_STEPS - 1)) state_next = FE_DONE;
      end
      FE_DONE: begin
        if (!q_full) begin
          wr_en      = 1'b1;
          state_next = FE_IDLE;
        end
      end
      default: state_next = FE_IDLE;
    endcase
  end

endmodule

### src/uaf_queue.sv
// ----------------------------------------------------------------------------
// uaf_queue
// Two-entry queue of digit records between the front and back ends.
// ----------------------------------------------------------------------------
module uaf_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  uaf_pkg::entry_t wr_entry,
  output logic            q_full,
  input  logic            rd_en,
  output uaf_pkg::entry_t rd_entry,
  output logic            q_empty
);
  import uaf_pkg::*;

  entry_t     mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] fill;

  assign q_full   = (fill == 2'd2);
  assign q_empty  = (fill == 2'd0);
  assign rd_entry = mem[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_entry;
  end

endmodule

### src/uaf_back.sv
// ----------------------------------------------------------------------------
// uaf_back
// Walks the head record from its top digit down into an output register,
// one character per cycle while pop or an empty output register frees it.
// ----------------------------------------------------------------------------
module uaf_back (
  input  logic            clk,
  input  logic            rst,
  input  uaf_pkg::entry_t rd_entry,
  input  logic            q_empty,
  output logic            rd_en,
  output logic            empty,
  input  logic            pop,
  output logic [7:0]      character,
  output logic [4:0]      digit_count,
  output logic            last
);
  import uaf_pkg::*;

  logic       out_valid;
  logic       started;
  logic [3:0] idx;
  logic [3:0] cur;
  logic       load;

  // Current digit position in the head record
  assign cur   = started ? idx : 4'(rd_entry.count - 5'd1);
  assign load  = !q_empty && (!out_valid || pop);
  assign rd_en = load && (cur == 4'd0);
  assign empty = !out_valid;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      started   <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        started   <= (cur != 4'd0);
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload and digit index
  always_ff @(posedge clk) begin
    if (load) begin
      character   <= to_ascii(rd_entry.digits[cur*4 +: 4], rd_entry.upper);
      digit_count <= rd_entry.count;
      last        <= (cur == 4'd0);
      idx         <= cur - 4'd1;
    end
  end

endmodule

### src/unsigned_to_ascii_formatter_top.sv
// ----------------------------------------------------------------------------
// unsigned_to_ascii_formatter_top
// Formats an unsigned number as hex (64-bit) or decimal (low 32 bits) ASCII.
// ----------------------------------------------------------------------------
// Throughput: one character per cycle while pop keeps the output register free;
// the front end can convert the next item while the back end emits characters.
// Reset: synchronous rst empties the queue and output; no clearing pass.
module unsigned_to_ascii_formatter_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [63:0] value,
  input  logic [1:0]  func,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  character,
  output logic [4:0]  digit_count,
  output logic        last
);
  import uaf_pkg::*;

  entry_t wr_entry, rd_entry;
  logic   wr_en, rd_en, q_full, q_empty;

  // Front end: accept and convert
  uaf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .value    (value),
    .func     (func),
    .q_full   (q_full),
    .wr_en    (wr_en),
    .wr_entry (wr_entry)
  );

  // Decoupling queue
  uaf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_entry (wr_entry),
    .q_full   (q_full),
    .rd_en    (rd_en),
    .rd_entry (rd_entry),
    .q_empty  (q_empty)
  );

  // Back end: emit characters
  uaf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .rd_entry    (rd_entry),
    .q_empty     (q_empty),
    .rd_en       (rd_en),
    .empty       (empty),
    .pop         (pop),
    .character   (character),
    .digit_count (digit_count),
    .last        (last)
  );

endmodule
